FILE: rtl/rpw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the receive page record walker.
package rpw_pkg;

    localparam int RECORD_BYTES = 16;
    localparam int OFS_W        = 17;
    localparam int SUM_W        = OFS_W + 1;
    localparam int SEQ_W        = 16;
    localparam int SIZE_W       = 14;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int ALIGN_BYTES  = 32;
    localparam int FCS_BYTES    = 4;
    localparam int ERR_FLAG_BIT = 9;
    localparam int RAW_LSB      = 16;
    localparam int ALIGN_W      = 15;

    localparam logic [15:0] RECYCLE_AT_RST  = 16'd16384;
    localparam logic [15:0] ALLOC_BYTES_RST = 16'd17920;
    localparam logic [13:0] MAX_PAYLOAD_RST = 14'd1514;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RECYCLE_AT  = 2'd0,
        REG_ALLOC_BYTES = 2'd1,
        REG_MAX_PAYLOAD = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ACT_IDLE     = 3'd0,
        ACT_DELIVER  = 3'd1,
        ACT_DROP     = 3'd2,
        ACT_RUNT     = 3'd3,
        ACT_SEQ_ERR  = 3'd4,
        ACT_OVERRUN  = 3'd5
    } action_t;

    typedef struct packed {
        logic [15:0]       recycle_at;
        logic [15:0]       alloc_bytes;
        logic [SIZE_W-1:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic [15:0] hw_wr_ofs;
        logic [15:0] rec_seq;
        logic [31:0] rec_word1;
        logic [15:0] rec_flags;
    } item_t;

    typedef struct packed {
        logic                           page;
        logic [SEQ_W-1:0]               expected_seq;
        logic [1:0][OFS_W-1:0]          rd_ofs;
    } walk_state_t;

    typedef struct packed {
        action_t           action;
        logic              page_index;
        logic [15:0]       payload_offset;
        logic [SIZE_W-1:0] payload_len;
        logic              recycled;
        logic [OFS_W-1:0]  next_read_offset;
        logic [SEQ_W-1:0]  expected_seq_out;
    } result_t;

endpackage

FILE: rtl/rpw_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration registers of the receive page record walker.
module rpw_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rpw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpw_pkg::CFG_W-1:0]      cfg_data,
    output rpw_pkg::cfg_t                  cfg
);

    rpw_pkg::cfg_t cfg_reg;
    rpw_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                rpw_pkg::REG_RECYCLE_AT:  cfg_next.recycle_at  = cfg_data;
                rpw_pkg::REG_ALLOC_BYTES: cfg_next.alloc_bytes = cfg_data;
                rpw_pkg::REG_MAX_PAYLOAD:
                    cfg_next.max_payload = cfg_data[rpw_pkg::SIZE_W-1:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.recycle_at  <= rpw_pkg::RECYCLE_AT_RST;
            cfg_reg.alloc_bytes <= rpw_pkg::ALLOC_BYTES_RST;
            cfg_reg.max_payload <= rpw_pkg::MAX_PAYLOAD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/rpw_step.sv
`timescale 1ns / 1ps
// Combinational walk step: classifies one record and computes the next walk state.
module rpw_step
(
    input  rpw_pkg::cfg_t        cfg,
    input  rpw_pkg::walk_state_t cur,
    input  rpw_pkg::item_t       item,
    output rpw_pkg::walk_state_t nxt,
    output rpw_pkg::result_t     res
);

    logic [rpw_pkg::OFS_W-1:0]    ro;
    logic [rpw_pkg::SUM_W-1:0]    ro_rec;
    logic [rpw_pkg::SIZE_W-1:0]   raw;
    logic [rpw_pkg::SIZE_W-1:0]   plen;
    logic                         err;
    logic                         fits;
    logic [rpw_pkg::ALIGN_W-1:0]  rec_span;
    logic [rpw_pkg::OFS_W-1:0]    ro_new;

    always_comb
    begin
        ro       = cur.rd_ofs[cur.page];
        ro_rec   = {1'b0, ro} + rpw_pkg::SUM_W'(rpw_pkg::RECORD_BYTES);
        raw      = item.rec_word1[rpw_pkg::RAW_LSB +: rpw_pkg::SIZE_W];
        err      = item.rec_flags[rpw_pkg::ERR_FLAG_BIT];
        plen     = raw - rpw_pkg::SIZE_W'(rpw_pkg::FCS_BYTES);
        fits     = (ro_rec + rpw_pkg::SUM_W'(plen)) <= rpw_pkg::SUM_W'(cfg.alloc_bytes);
        // Record plus payload, rounded up to the next 32-byte boundary.
        rec_span = (rpw_pkg::ALIGN_W'(raw)
                    + rpw_pkg::ALIGN_W'(rpw_pkg::RECORD_BYTES + rpw_pkg::ALIGN_BYTES - 1))
                   & ~rpw_pkg::ALIGN_W'(rpw_pkg::ALIGN_BYTES - 1);
        ro_new   = ro + rpw_pkg::OFS_W'(rec_span);

        nxt = cur;
        res.action           = rpw_pkg::ACT_IDLE;
        res.page_index       = cur.page;
        res.payload_offset   = '0;
        res.payload_len      = '0;
        res.recycled         = 1'b0;

        if (ro >= rpw_pkg::OFS_W'(item.hw_wr_ofs))
        begin
            res.action = rpw_pkg::ACT_IDLE;
        end
        else if (ro_rec > rpw_pkg::SUM_W'(cfg.alloc_bytes))
        begin
            res.action            = rpw_pkg::ACT_OVERRUN;
            res.recycled          = 1'b1;
            nxt.rd_ofs[cur.page]  = '0;
            nxt.page              = ~cur.page;
        end
        else if (item.rec_seq != cur.expected_seq)
        begin
            res.action            = rpw_pkg::ACT_SEQ_ERR;
            res.recycled          = 1'b1;
            nxt.expected_seq      = item.rec_seq + rpw_pkg::SEQ_W'(1);
            nxt.rd_ofs[cur.page]  = '0;
            nxt.page              = ~cur.page;
        end
        else
        begin
            nxt.expected_seq   = cur.expected_seq + rpw_pkg::SEQ_W'(1);
            res.payload_offset = ro_rec[15:0];
            if (err)
            begin
                res.action = rpw_pkg::ACT_DROP;
            end
            else if (raw > rpw_pkg::SIZE_W'(rpw_pkg::FCS_BYTES))
            begin
                if (plen <= cfg.max_payload && fits)
                begin
                    res.action      = rpw_pkg::ACT_DELIVER;
                    res.payload_len = plen;
                end
                else
                begin
                    res.action = rpw_pkg::ACT_DROP;
                end
            end
            else
            begin
                res.action = rpw_pkg::ACT_RUNT;
            end

            if (ro_new >= rpw_pkg::OFS_W'(cfg.recycle_at))
            begin
                res.recycled          = 1'b1;
                nxt.rd_ofs[cur.page]  = '0;
                nxt.page              = ~cur.page;
            end
            else
            begin
                nxt.rd_ofs[cur.page]  = ro_new;
            end
        end

        // Offset of the page just worked on, zero once it has been recycled.
        res.next_read_offset = nxt.rd_ofs[cur.page];
        res.expected_seq_out = nxt.expected_seq;
    end

endmodule

FILE: rtl/rx_page_record_walker.sv
`timescale 1ns / 1ps
// Top level of the receive page record walker: input register, step logic, result register.
// Flow: an accepted item waits in the input register until the result register is free or
// being emptied; it is then walked and its result is registered, which raises out_valid.
// Throughput: one item per cycle while out_ready is high; the walk state is updated in the same cycle as the
// step logic runs, so each item sees the state left by the one before it.
// Reset: page 0 in use, expected sequence 0, both read offsets 0, and the
// configuration registers at 16384, 17920 and 1514; no result is pending.
module rx_page_record_walker
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [rpw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rpw_pkg::CFG_W-1:0]           cfg_data,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [15:0]                         hw_wr_ofs,
    input  logic [15:0]                         rec_seq,
    input  logic [31:0]                         rec_word1,
    input  logic [15:0]                         rec_flags,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [2:0]                          action,
    output logic                                page_index,
    output logic [15:0]                         payload_offset,
    output logic [rpw_pkg::SIZE_W-1:0]          payload_len,
    output logic                                recycled,
    output logic [rpw_pkg::OFS_W-1:0]           next_read_offset,
    output logic [rpw_pkg::SEQ_W-1:0]           expected_seq_out
);

    rpw_pkg::cfg_t        cfg;
    rpw_pkg::item_t       item_reg;
    logic                 item_valid_reg;
    rpw_pkg::walk_state_t state_reg;
    rpw_pkg::walk_state_t state_next;
    rpw_pkg::result_t     step_res;
    rpw_pkg::result_t     res_reg;
    logic                 res_valid_reg;
    logic                 step_fire;
    logic                 in_fire;

    rpw_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rpw_step u_step
    (
        .cfg  (cfg),
        .cur  (state_reg),
        .item (item_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    // The registered item is walked when the result register is free or is
    // being emptied in this cycle. The input register refills in the same cycle.
    assign step_fire = item_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || step_fire;
    assign in_fire   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (step_fire)
            begin
                item_valid_reg <= 1'b0;
            end

            if (step_fire)
            begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.hw_wr_ofs <= hw_wr_ofs;
            item_reg.rec_seq   <= rec_seq;
            item_reg.rec_word1 <= rec_word1;
            item_reg.rec_flags <= rec_flags;
        end
        if (step_fire)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid        = res_valid_reg;
    assign action           = res_reg.action;
    assign page_index       = res_reg.page_index;
    assign payload_offset   = res_reg.payload_offset;
    assign payload_len      = res_reg.payload_len;
    assign recycled         = res_reg.recycled;
    assign next_read_offset = res_reg.next_read_offset;
    assign expected_seq_out = res_reg.expected_seq_out;

endmodule
